// ===== design/laser_camera_stage_sequencer_core_assert.svh =====
// Assertion macros shared by the sequencer checker.
// Each macro expands to one labeled concurrent assertion clocked on a rising edge.
`ifndef LASER_CAMERA_STAGE_SEQUENCER_CORE_ASSERT_SVH
`define LASER_CAMERA_STAGE_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LCSS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sequencer check failed");

// Next-cycle implication, disabled during reset.
`define LCSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sequencer check failed");

`endif

// ===== design/lcss_pkg.sv =====
// Package for the laser/camera/stage sequencer: transaction payload types,
// register indexes, reset values and timer width. No dependencies.
`default_nettype none

package lcss_pkg;

   localparam int TIMER_W = 26;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_EXPOSURE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_READOUT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STAGE_PULSE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FRAMES = 2'd3;

   localparam logic [15:0] EXPOSURE_RST = 16'd300;
   localparam logic [9:0] READOUT_RST = 10'd40;
   localparam logic [15:0] STAGE_PULSE_RST = 16'd2000;
   localparam logic [15:0] MAX_FRAMES_RST = 16'd2000;

   localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

   typedef struct packed {
      logic start_request;
      logic camera_active;
      logic stage_busy;
   } req_type;

   typedef struct packed {
      logic        laser_on;
      logic        camera_trigger;
      logic        led_on;
      logic        stage_trigger;
      logic        running;
      logic [15:0] frames_done;
      logic        aborted;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/laser_camera_stage_sequencer_core.sv =====
// Latency: the result for a tick transaction is in the output register the cycle after accept.
// Throughput: one tick per clock; req_stall rises only while a held result is stalled.
// Exposure and readout tick counts are scaled at csr write time by one shared multiplier.
// Reset (synchronous, active high): idle, timer and frame count zero, abort clear,
// registers back to 300 ms / 40 ms / 2000 us / 2000 frames, output register empty.
// Depends on lcss_pkg.
`default_nettype none

module laser_camera_stage_sequencer_core #(
   parameter int TICKS_PER_MS = 1000,
   parameter int COUNT_WIDTH = 16
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  lcss_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output lcss_pkg::rsp_type                     rsp_data,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [lcss_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [lcss_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int TW = lcss_pkg::TIMER_W;
   localparam int TICKS_W = $clog2(TICKS_PER_MS + 1);
   localparam int PROD_W = 16 + TICKS_W;

   localparam logic [63:0] EXP_RST_RAW =
      64'(lcss_pkg::EXPOSURE_RST >> 1) * 64'(TICKS_PER_MS);
   localparam logic [63:0] READ_RST_RAW = 64'(lcss_pkg::READOUT_RST) * 64'(TICKS_PER_MS);
   localparam logic [TW-1:0] EXP_TICKS_RST =
      (EXP_RST_RAW > 64'(lcss_pkg::TIMER_MAX)) ? lcss_pkg::TIMER_MAX : EXP_RST_RAW[TW-1:0];
   localparam logic [TW-1:0] READ_TICKS_RST =
      (READ_RST_RAW > 64'(lcss_pkg::TIMER_MAX)) ? lcss_pkg::TIMER_MAX : READ_RST_RAW[TW-1:0];

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_EXP1 = 3'd1;
   localparam logic [2:0] PH_EXP2 = 3'd2;
   localparam logic [2:0] PH_READ = 3'd3;
   localparam logic [2:0] PH_PULSE = 3'd4;
   localparam logic [2:0] PH_WAIT = 3'd5;

   // configuration, timed values kept in ticks
   logic [TW-1:0]          exp_ticks_ff;
   logic [TW-1:0]          read_ticks_ff;
   logic [15:0]            pulse_us_ff;
   logic [15:0]            max_frames_ff;

   logic [2:0]             phase_ff, phase_in;
   logic [TW-1:0]          timer_ff, timer_in;
   logic [COUNT_WIDTH-1:0] frame_ff, frame_in;
   logic                   abort_ff, abort_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   lcss_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic                   csr_write;
   logic [15:0]            mul_op;
   logic [PROD_W-1:0]      prod;
   logic [63:0]            prod_ext;
   logic [TW-1:0]          sat_ticks;
   logic [TW-1:0]          timer_dec;
   logic                   expired;
   logic [COUNT_WIDTH-1:0] frame_inc;
   logic [31:0]            frame_ext;
   logic                   light;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   // one multiplier serves both millisecond registers
   assign mul_op    = (csr_index == lcss_pkg::CSR_EXPOSURE) ? {1'b0, csr_wdata[15:1]}
                                                            : {6'b0, csr_wdata[9:0]};
   assign prod      = PROD_W'(mul_op) * PROD_W'(TICKS_PER_MS);
   assign prod_ext  = 64'(prod);
   assign sat_ticks = (prod_ext > 64'(lcss_pkg::TIMER_MAX)) ? lcss_pkg::TIMER_MAX
                                                            : prod_ext[TW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ticks_ff  <= EXP_TICKS_RST;
         read_ticks_ff <= READ_TICKS_RST;
         pulse_us_ff   <= lcss_pkg::STAGE_PULSE_RST;
         max_frames_ff <= lcss_pkg::MAX_FRAMES_RST;
      end else if (csr_write) begin
         case (csr_index)
            lcss_pkg::CSR_EXPOSURE:    exp_ticks_ff  <= sat_ticks;
            lcss_pkg::CSR_READOUT:     read_ticks_ff <= sat_ticks;
            lcss_pkg::CSR_STAGE_PULSE: pulse_us_ff   <= csr_wdata;
            lcss_pkg::CSR_MAX_FRAMES:  max_frames_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      timer_dec = timer_ff;
      if ((phase_ff inside {PH_EXP1, PH_EXP2, PH_READ, PH_PULSE}) && (timer_ff != '0)) begin
         timer_dec = timer_ff - 1'b1;
      end
      expired   = (timer_dec == '0);
      frame_inc = frame_ff + 1'b1;

      phase_in = phase_ff;
      timer_in = timer_dec;
      frame_in = frame_ff;
      abort_in = abort_ff;

      case (phase_ff)
         PH_EXP1: begin
            if (expired) begin
               if (req_data.camera_active) begin
                  phase_in = PH_EXP2;
                  timer_in = exp_ticks_ff;
               end else begin
                  abort_in = 1'b1;
                  phase_in = PH_PULSE;
                  timer_in = TW'(pulse_us_ff);
               end
            end
         end
         PH_EXP2: begin
            if (expired) begin
               phase_in = PH_READ;
               timer_in = read_ticks_ff;
            end
         end
         PH_READ: begin
            if (expired) begin
               phase_in = PH_PULSE;
               timer_in = TW'(pulse_us_ff);
            end
         end
         PH_PULSE: begin
            if (expired) begin
               phase_in = PH_WAIT;
            end
         end
         PH_WAIT: begin
            if (!req_data.stage_busy) begin
               if (abort_ff) begin
                  phase_in = PH_IDLE;
               end else begin
                  frame_in = frame_inc;
                  if (32'(frame_inc) >= 32'(max_frames_ff)) begin
                     phase_in = PH_IDLE;
                  end else begin
                     phase_in = PH_EXP1;
                     timer_in = exp_ticks_ff;
                  end
               end
            end
         end
         default: begin
            // idle, and any unused code falls back to idle
            phase_in = PH_IDLE;
            timer_in = '0;
            if (req_data.start_request) begin
               frame_in = '0;
               abort_in = 1'b0;
               if (max_frames_ff != '0) begin
                  phase_in = PH_EXP1;
                  timer_in = exp_ticks_ff;
               end
            end
         end
      endcase
   end

   always_comb begin
      light     = (phase_in == PH_EXP1) || (phase_in == PH_EXP2);
      frame_ext = 32'(frame_in);
      rsp_data_in.laser_on       = light;
      rsp_data_in.camera_trigger = light;
      rsp_data_in.led_on         = light;
      rsp_data_in.stage_trigger  = (phase_in == PH_PULSE);
      rsp_data_in.running        = (phase_in != PH_IDLE);
      rsp_data_in.frames_done    = frame_ext[15:0];
      rsp_data_in.aborted        = abort_in;
      rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         timer_ff     <= '0;
         frame_ff     <= '0;
         abort_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff <= phase_in;
            timer_ff <= timer_in;
            frame_ff <= frame_in;
            abort_ff <= abort_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== design/lcss_checker.sv =====
// Port-level checker for the sequencer, attached to the top level by bind.
// Depends on lcss_pkg and laser_camera_stage_sequencer_core_assert.svh.
`default_nettype none
`include "laser_camera_stage_sequencer_core_assert.svh"

module lcss_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_valid,
   input wire                              req_stall,
   input lcss_pkg::req_type                req_data,
   input wire                              rsp_valid,
   input wire                              rsp_stall,
   input lcss_pkg::rsp_type                rsp_data,
   input wire                              csr_valid,
   input wire                              csr_ready,
   input wire [lcss_pkg::CSR_IDX_W-1:0]    csr_index,
   input wire [lcss_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // input side only backs up behind a held result
   `LCSS_ASSERT_SAME(a_stall_needs_held_rsp, clock, reset, req_stall, rsp_valid && rsp_stall)

   // every accepted tick transaction yields a result next cycle
   `LCSS_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, req_valid && !req_stall, rsp_valid)

   // laser, camera trigger and LED move together, never with the stage pulse
   `LCSS_ASSERT_SAME(a_light_outputs, clock, reset, rsp_valid,
      (rsp_data.laser_on == rsp_data.camera_trigger) &&
      (rsp_data.camera_trigger == rsp_data.led_on) &&
      !(rsp_data.laser_on && rsp_data.stage_trigger))

   // any active output implies a run in progress
   `LCSS_ASSERT_SAME(a_active_means_running, clock, reset,
      rsp_valid && (rsp_data.laser_on || rsp_data.stage_trigger), rsp_data.running)

   // a stalled result holds
   `LCSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data))

endmodule

bind laser_camera_stage_sequencer_core lcss_checker u_lcss_checker (.*);

`default_nettype wire

// ===== tb/sv/lcss_sequencer_checker.sv =====
// Scoreboard for laser_camera_stage_sequencer_core: mirrors the tick sequencer,
// predicts every result transaction and compares it with the DUT output.
// Depends on lcss_pkg.
`timescale 1ns / 100ps

module lcss_sequencer_checker #(
   parameter int TICKS_PER_MS = 1000,
   parameter int COUNT_WIDTH = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   input  wire                                req_stall,
   input  lcss_pkg::req_type                  req_data,
   input  wire                                rsp_valid,
   input  wire                                rsp_stall,
   input  lcss_pkg::rsp_type                  rsp_data,
   input  wire                                csr_valid,
   input  wire                                csr_ready,
   input  wire [lcss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [lcss_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                 pending,
   output int                                 mismatches
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXP1 = 3'd1;
   localparam logic [2:0] ST_EXP2 = 3'd2;
   localparam logic [2:0] ST_READ = 3'd3;
   localparam logic [2:0] ST_PULSE = 3'd4;
   localparam logic [2:0] ST_WAIT = 3'd5;

   // mirrored configuration
   logic [15:0] exposure_ms;
   logic [9:0]  readout_ms;
   logic [15:0] pulse_us;
   logic [15:0] frame_limit;

   // mirrored sequencer state
   logic [2:0]                      seq_state;
   logic [lcss_pkg::TIMER_W-1:0]    tick_count;
   logic [COUNT_WIDTH-1:0]          frame_count;
   logic                            run_aborted;

   lcss_pkg::rsp_type predicted_levels [$];

   initial begin
      pending = 0;
      mismatches = 0;
   end

   function automatic logic [lcss_pkg::TIMER_W-1:0] load_ticks(input longint unsigned n);
      return (n > longint'(lcss_pkg::TIMER_MAX)) ? lcss_pkg::TIMER_MAX
                                                  : n[lcss_pkg::TIMER_W-1:0];
   endfunction

   function automatic logic [lcss_pkg::TIMER_W-1:0] half_exposure_ticks();
      return load_ticks(longint'(exposure_ms >> 1) * TICKS_PER_MS);
   endfunction

   // One tick of the sequencer; returns the output levels after the update.
   function automatic lcss_pkg::rsp_type advance_tick(input lcss_pkg::req_type t);
      logic              expired;
      logic              light;
      lcss_pkg::rsp_type r;
      if (seq_state != ST_IDLE && seq_state <= ST_PULSE && tick_count != 0)
         tick_count = tick_count - 1'b1;
      expired = (tick_count == 0);
      case (seq_state)
         ST_EXP1: begin
            if (expired) begin
               if (t.camera_active) begin
                  seq_state = ST_EXP2;
                  tick_count = half_exposure_ticks();
               end else begin
                  run_aborted = 1'b1;
                  seq_state = ST_PULSE;
                  tick_count = load_ticks(64'(pulse_us));
               end
            end
         end
         ST_EXP2: begin
            if (expired) begin
               seq_state = ST_READ;
               tick_count = load_ticks(longint'(readout_ms) * TICKS_PER_MS);
            end
         end
         ST_READ: begin
            if (expired) begin
               seq_state = ST_PULSE;
               tick_count = load_ticks(64'(pulse_us));
            end
         end
         ST_PULSE: begin
            if (expired)
               seq_state = ST_WAIT;
         end
         ST_WAIT: begin
            if (!t.stage_busy) begin
               if (run_aborted) begin
                  seq_state = ST_IDLE;
               end else begin
                  frame_count = frame_count + 1'b1;
                  if (frame_count >= frame_limit) begin
                     seq_state = ST_IDLE;
                  end else begin
                     seq_state = ST_EXP1;
                     tick_count = half_exposure_ticks();
                  end
               end
            end
         end
         default: begin
            seq_state = ST_IDLE;
            tick_count = '0;
            if (t.start_request) begin
               frame_count = '0;
               run_aborted = 1'b0;
               if (frame_limit != 0) begin
                  seq_state = ST_EXP1;
                  tick_count = half_exposure_ticks();
               end
            end
         end
      endcase
      light = (seq_state == ST_EXP1 || seq_state == ST_EXP2);
      r.laser_on = light;
      r.camera_trigger = light;
      r.led_on = light;
      r.stage_trigger = (seq_state == ST_PULSE);
      r.running = (seq_state != ST_IDLE);
      r.frames_done = 16'(frame_count);
      r.aborted = run_aborted;
      return r;
   endfunction

   task automatic compare_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      lcss_pkg::rsp_type want;
      if (reset) begin
         exposure_ms = lcss_pkg::EXPOSURE_RST;
         readout_ms = lcss_pkg::READOUT_RST;
         pulse_us = lcss_pkg::STAGE_PULSE_RST;
         frame_limit = lcss_pkg::MAX_FRAMES_RST;
         seq_state = ST_IDLE;
         tick_count = '0;
         frame_count = '0;
         run_aborted = 1'b0;
         predicted_levels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               lcss_pkg::CSR_EXPOSURE:    exposure_ms = csr_wdata;
               lcss_pkg::CSR_READOUT:     readout_ms = csr_wdata[9:0];
               lcss_pkg::CSR_STAGE_PULSE: pulse_us = csr_wdata;
               lcss_pkg::CSR_MAX_FRAMES:  frame_limit = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            predicted_levels.push_back(advance_tick(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (predicted_levels.size() == 0) begin
               $error("result transaction with no prediction pending");
               mismatches++;
            end else begin
               want = predicted_levels.pop_front();
               compare_field("laser_on", int'(want.laser_on), int'(rsp_data.laser_on));
               compare_field("camera_trigger", int'(want.camera_trigger),
                             int'(rsp_data.camera_trigger));
               compare_field("led_on", int'(want.led_on), int'(rsp_data.led_on));
               compare_field("stage_trigger", int'(want.stage_trigger),
                             int'(rsp_data.stage_trigger));
               compare_field("running", int'(want.running), int'(rsp_data.running));
               compare_field("frames_done", int'(want.frames_done),
                             int'(rsp_data.frames_done));
               compare_field("aborted", int'(want.aborted), int'(rsp_data.aborted));
            end
         end
      end
      pending <= predicted_levels.size();
   end

endmodule

// ===== tb/sv/tb_laser_camera_stage_sequencer_core.sv =====
// Top of the sequencer testbench: clock, reset, tick and register stimulus, random
// idling on both channels and the verdict. Depends on lcss_pkg, the DUT and
// lcss_sequencer_checker.
`timescale 1ns / 100ps

module tb_laser_camera_stage_sequencer_core;

   localparam int TICKS_PER_MS = 1000;
   // random segments run until this many ticks have been sent in total
   localparam int RANDOM_TICKS = 900;
   localparam int CYCLE_LIMIT = 4_000_000;

   // start_request, camera_active, stage_busy per entry
   localparam logic [2:0] TOUR [26] = '{
      3'b000, 3'b011,                          // idle, no start
      3'b110, 3'b111, 3'b000, 3'b101,          // full frame, starts ignored while running
      3'b010, 3'b010, 3'b011,                  // stage pulse
      3'b011, 3'b111, 3'b010,                  // stage held busy, then next frame
      3'b001,                                  // camera dropped: abort
      3'b011, 3'b011, 3'b011, 3'b001, 3'b000,  // pulse, wait, back to idle uncounted
      3'b110, 3'b010, 3'b010, 3'b010,          // restart clears count and abort
      3'b010, 3'b010, 3'b010, 3'b010
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   lcss_pkg::req_type     req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   lcss_pkg::rsp_type     rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [lcss_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [lcss_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   int pending;
   int mismatches;
   bit quiet = 1'b0;
   int sender_calm = 0;
   int stall_left = 0;
   int stall_calm = 0;
   int cycle_count = 0;
   int ticks_sent = 0;

   // configuration currently loaded, for sizing the drain
   logic [15:0] cur_exposure, cur_readout, cur_pulse, cur_frames;

   laser_camera_stage_sequencer_core #(
      .TICKS_PER_MS(TICKS_PER_MS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   lcss_sequencer_checker #(
      .TICKS_PER_MS(TICKS_PER_MS)
   ) checker_i (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .pending(pending),
      .mismatches(mismatches)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // result side backpressure: bursts of stall separated by calm stretches
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (stall_calm > 0) begin
            stall_calm--;
         end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14);
            if ($urandom_range(0, 3) == 0)
               stall_calm = $urandom_range(20, 200);
         end
      end
   end

   task automatic send_tick(input lcss_pkg::req_type t);
      int gap;
      if (!quiet && sender_calm == 0 && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         if ($urandom_range(0, 3) == 0)
            sender_calm = $urandom_range(20, 200);
      end else if (sender_calm > 0) begin
         sender_calm--;
      end
      req_data <= t;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      ticks_sent++;
   endtask

   // stop sending and let every predicted result drain out of the DUT
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_config(input logic [15:0] exp_ms, rd_ms, pulse, frames);
      logic [lcss_pkg::CSR_IDX_W-1:0] idx [4];
      logic [15:0]                    val [4];
      idx = '{lcss_pkg::CSR_EXPOSURE, lcss_pkg::CSR_READOUT, lcss_pkg::CSR_STAGE_PULSE,
              lcss_pkg::CSR_MAX_FRAMES};
      val = '{exp_ms, rd_ms, pulse, frames};
      settle();
      for (int i = 0; i < 4; i++) begin
         csr_index <= idx[i];
         csr_wdata <= val[i];
         csr_valid <= 1'b1;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      cur_exposure = exp_ms;
      cur_readout = rd_ms;
      cur_pulse = pulse;
      cur_frames = frames;
   endtask

   // camera and stage both released: any run in flight ends within this bound
   task automatic drain_run();
      longint n;
      n = 0;
      if (cur_frames != 0)
         n = 2 * longint'(cur_exposure >> 1) * TICKS_PER_MS
             + longint'(cur_readout) * TICKS_PER_MS
             + longint'(cur_pulse) * ((cur_frames == 1) ? 1 : 2) + 16;
      repeat (n) send_tick('0);
   endtask

   function automatic lcss_pkg::req_type random_tick(input bit noisy);
      lcss_pkg::req_type t;
      if (noisy) begin
         t = lcss_pkg::req_type'(3'($urandom_range(0, 7)));
      end else begin
         t.start_request = ($urandom_range(0, 7) == 0);
         t.camera_active = ($urandom_range(0, 15) != 0);
         t.stage_busy = ($urandom_range(0, 2) == 0);
      end
      return t;
   endfunction

   initial begin
      int          n;
      bit          noisy;
      logic [15:0] exp_ms, rd_ms, pulse, frames;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed tour with zero-length exposure and readout halves
      apply_config(16'd1, 16'd0, 16'd3, 16'd2);
      foreach (TOUR[i])
         send_tick(lcss_pkg::req_type'(TOUR[i]));
      drain_run();

      // all-max timing with zero frame limit: starts only clear the status
      apply_config(16'hFFFF, 16'd1023, 16'hFFFF, 16'd0);
      repeat (20) send_tick(random_tick(1'b1));

      while (ticks_sent < RANDOM_TICKS) begin
         exp_ms = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(2, 3))
                                                : 16'($urandom_range(0, 1));
         rd_ms = ($urandom_range(0, 15) == 0) ? 16'd1 : 16'd0;
         pulse = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(21, 200))
                                              : 16'($urandom_range(0, 20));
         case ($urandom_range(0, 9))
            0:       frames = 16'd0;
            1:       frames = 16'hFFFF;
            default: frames = 16'($urandom_range(1, 6));
         endcase
         noisy = ($urandom_range(0, 4) == 0);
         n = $urandom_range(100, 200);
         apply_config(exp_ms, rd_ms, pulse, frames);
         repeat (n) send_tick(random_tick(noisy));
         drain_run();
      end

      // long stage pulse, single frame
      apply_config(16'd0, 16'd0, 16'd300, 16'd1);
      send_tick(lcss_pkg::req_type'(3'b110));
      repeat (30) send_tick(random_tick(1'b0));
      drain_run();

      // closing stretch at full rate on both sides
      quiet = 1'b1;
      apply_config(16'd0, 16'd0, 16'd2, 16'hFFFF);
      repeat (80) send_tick(random_tick(1'b0));
      drain_run();

      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
